FILE: rtl/gfbc_pkg.sv
// ----------------------------------------------------------------------------
// gfbc_pkg: shared types and constants for the Feistel block cipher
// Command codes, round schedule, key bank type and the control/status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package gfbc_pkg;

  // Fixed cipher geometry
  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned RND_W     = $clog2(ROUNDS);
  localparam int unsigned ROT_L     = 11;
  localparam int unsigned NUM_KEYS  = 8;
  localparam int unsigned KIDX_W    = $clog2(NUM_KEYS);
  localparam int unsigned NIB_N     = 8;
  localparam int unsigned ROW_W     = 64;
  localparam int unsigned BLK_W     = 64;
  localparam int unsigned KREG_N    = 4;
  localparam int unsigned IN_DATA_W = 136;

  localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);
  // Rounds that run with ascending key order before the key order reverses
  localparam logic [RND_W-1:0] FWD_ENC  = RND_W'(ROUNDS - 8);
  localparam logic [RND_W-1:0] FWD_DEC  = RND_W'(8);

  // Input command codes carried on tuser
  localparam logic [1:0] CMD_ENC  = 2'd0;
  localparam logic [1:0] CMD_DEC  = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  typedef logic [KREG_N-1:0][63:0] key_bank_t;

  // Controller to datapath
  typedef struct packed {
    logic              load_blk;
    logic              round_en;
    logic              row_rd_en;
    logic [KIDX_W-1:0] row_addr;
    logic [KIDX_W-1:0] key_sel;
    logic              row_wr;
    logic              out_load;
  } gfbc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } gfbc_sts_t;

  // Key and S-box row index used by a given round
  function automatic logic [KIDX_W-1:0] key_idx(input logic [RND_W-1:0] rnd,
                                                input logic dec);
    logic [RND_W-1:0] fwd;
    fwd = dec ? FWD_DEC : FWD_ENC;
    if (rnd < fwd) begin
      return rnd[KIDX_W-1:0];
    end
    return ~rnd[KIDX_W-1:0];
  endfunction

endpackage

FILE: rtl/gost_feistel_block_cipher.sv
// ----------------------------------------------------------------------------
// gost_feistel_block_cipher: 32-round Feistel block cipher, ECB
// Usage:
//   Input stream (in_*): tuser carries the command (encrypt, decrypt,
//   load S-box row); tdata carries the block and the row to load.
//   A load writes one S-box row at its transfer and returns no result;
//   command code 3 is dropped. S-box rows must be loaded before use.
//   Output stream (out_*): one 64-bit block per encrypt or decrypt.
//   Key: four 64-bit registers on the APB port, written while idle.
// Timing:
//   A cipher command runs its rounds after its transfer, one round per cycle
//   through the single round unit, its S-box row fetched from the row store
//   in the cycle before; the finished block is then handed to the output
//   register, which drives out_tvalid. A load command completes in its
//   transfer cycle. A new input transfer is taken once the previous block
//   is in the output register, so no new block is taken while one is in
//   progress; a stalled receiver holds the result and halts the core once a
//   second block is finished.
// Reset: rst_n clears the keys and the control state; S-box rows are
//   undefined until loaded.
// ----------------------------------------------------------------------------
module gost_feistel_block_cipher (
  input  logic          clk,
  input  logic          rst_n,
  // Input stream
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [135:0]  in_tdata,   // data_block[63:0], sbox_row_index[66:64],
                                    // sbox_row_value[130:67], zero[135:131]
  input  logic [1:0]    in_tuser,   // cmd[1:0]
  // Result stream
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // result_block[63:0]
  // Configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import gfbc_pkg::*;

  gfbc_cmd_t dp_cmd;
  gfbc_sts_t dp_sts;
  key_bank_t keys;

  gfbc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .keys    (keys)
  );

  gfbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  gfbc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .sts        (dp_sts),
    .keys       (keys),
    .blk_in     (in_tdata[63:0]),
    .row_idx    (in_tdata[66:64]),
    .row_val    (in_tdata[130:67]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/gfbc_cfg.sv
// ----------------------------------------------------------------------------
// gfbc_cfg: key register bank behind the APB-style port
// Four 64-bit key registers at byte addresses 0, 8, 16 and 24.
// ----------------------------------------------------------------------------
module gfbc_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output gfbc_pkg::key_bank_t keys
);
  import gfbc_pkg::*;

  key_bank_t key_r;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write the addressed key register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (wr_en) begin
      key_r[paddr[4:3]] <= pwdata;
    end
  end

  // Return the addressed register on reads
  assign prdata = key_r[paddr[4:3]];
  assign keys   = key_r;

endmodule

FILE: rtl/gfbc_dp.sv
// ----------------------------------------------------------------------------
// gfbc_dp: cipher datapath
// Holds the S-box rows, the N1/N2 half registers, the round function and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module gfbc_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gfbc_pkg::gfbc_cmd_t    cmd,
  output gfbc_pkg::gfbc_sts_t    sts,
  input  gfbc_pkg::key_bank_t    keys,
  input  logic [63:0]            blk_in,
  input  logic [2:0]             row_idx,
  input  logic [63:0]            row_val,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [63:0]            out_tdata
);
  import gfbc_pkg::*;

  logic [ROW_W-1:0] sbox_mem [NUM_KEYS];
  logic [ROW_W-1:0] row_r;
  logic [31:0]      n1_r;
  logic [31:0]      n2_r;
  logic [BLK_W-1:0] out_data_r;
  logic             out_valid_r;
  logic [63:0]      kpair;
  logic [31:0]      subkey;
  logic [31:0]      sum;
  logic [31:0]      subst;
  logic [31:0]      fval;

  // S-box store: one whole row written per load, one row read per cycle while row_rd_en is set
  always_ff @(posedge clk) begin
    if (cmd.row_wr) begin
      sbox_mem[row_idx] <= row_val;
    end
    if (cmd.row_rd_en) begin
      row_r <= sbox_mem[cmd.row_addr];
    end
  end

  // Subkey select: even index in the upper half of its register
  assign kpair  = keys[cmd.key_sel[KIDX_W-1:1]];
  assign subkey = cmd.key_sel[0] ? kpair[31:0] : kpair[63:32];
  assign sum    = n1_r + subkey;

  // Substitute each nibble through the prefetched row
  always_comb begin
    for (int i = 0; i < NIB_N; i++) begin
      subst[4*i +: 4] = row_r[4*sum[4*i +: 4] +: 4];
    end
  end

  assign fval = {subst[31-ROT_L:0], subst[31:32-ROT_L]};

  // Load the block halves or advance one round
  always_ff @(posedge clk) begin
    if (cmd.load_blk) begin
      n1_r <= blk_in[63:32];
      n2_r <= blk_in[31:0];
    end else if (cmd.round_en) begin
      n1_r <= fval ^ n2_r;
      n2_r <= n1_r;
    end
  end

  // Output register: final N2 in the upper half
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {n2_r, n1_r};
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  // A new result never overwrites one still waiting for its transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before transfer");

endmodule

FILE: rtl/gfbc_ctrl.sv
// ----------------------------------------------------------------------------
// gfbc_ctrl: sequencing controller
// Accepts commands, steps the round counter through the key schedule and
// hands the finished block to the output register.
// ----------------------------------------------------------------------------
module gfbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_cmd,
  input  gfbc_pkg::gfbc_sts_t sts,
  output gfbc_pkg::gfbc_cmd_t cmd
);
  import gfbc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } state_t;

  state_t           state_r;
  logic [RND_W-1:0] rnd_r;
  logic             dec_r;
  logic             accept;
  logic             is_cipher;
  logic [RND_W-1:0] rnd_inc;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_cipher = (in_cmd == CMD_ENC) || (in_cmd == CMD_DEC);
  assign rnd_inc   = rnd_r + RND_W'(1);

  // State, round counter and direction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r   <= '0;
      dec_r   <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept && is_cipher) begin
            state_r <= S_RUN;
            rnd_r   <= '0;
            dec_r   <= (in_cmd == CMD_DEC);
          end
        end
        S_RUN: begin
          rnd_r <= rnd_inc;
          if (rnd_r == LAST_RND) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath commands; the row for the next round is fetched during the current one
  always_comb begin
    cmd           = '0;
    cmd.key_sel   = key_idx(rnd_r, dec_r);
    cmd.row_addr  = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load_blk  = accept && is_cipher;
        cmd.row_rd_en = accept && is_cipher;
        cmd.row_wr    = accept && (in_cmd == CMD_LOAD);
      end
      S_RUN: begin
        cmd.round_en  = 1'b1;
        cmd.row_rd_en = 1'b1;
        cmd.row_addr  = key_idx(rnd_inc, dec_r);
      end
      S_FINISH: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A cipher command starts the rounds from the first one
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_cipher) |=> (state_r == S_RUN && rnd_r == '0))
    else $error("cipher command did not start at round zero");

  // The last round always leads to the hand-off state
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && rnd_r == LAST_RND) |=> (state_r == S_FINISH))
    else $error("round sequence did not end after the last round");

  // Hold the finished block while the output register is occupied
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && !sts.out_free) |=> (state_r == S_FINISH))
    else $error("finished block dropped while output stalled");

endmodule

FILE: test/tb_gost_feistel_block_cipher.sv
// ----------------------------------------------------------------------------
// tb_gost_feistel_block_cipher: self-checking bench for the Feistel cipher
// Loads every S-box row, then runs directed and random encrypt, decrypt,
// row-load and dropped commands under several key settings and handshake
// idling patterns. A scoreboard predicts each result block and checks the
// output stream in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gost_feistel_block_cipher;
  import gfbc_pkg::*;

  // Unused command code: dropped by the block
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int unsigned ADDR_STRIDE  = 8;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_N      = 4;
  localparam int unsigned PHASE_ITEMS  = 300;
  localparam int unsigned REPORT_MAX   = 10;
  // Row whose entry i holds i
  localparam logic [ROW_W-1:0] IDENT_ROW = 64'hFEDC_BA98_7654_3210;

  // --------------------------------------------------------------------------
  // Scoreboard: key and S-box copies, predicted result blocks
  // --------------------------------------------------------------------------
  class cipher_checker;
    logic [63:0]      key_bank [KREG_N];
    logic [3:0]       sbox_rows [NUM_KEYS][16];
    logic [BLK_W-1:0] expected_blocks [$];
    int unsigned      mismatches;

    function new();
      foreach (key_bank[i]) key_bank[i] = '0;
      foreach (sbox_rows[r, e]) sbox_rows[r][e] = '0;
      mismatches = 0;
    endfunction

    function logic [31:0] subkey_word(int unsigned k);
      logic [63:0] pair;
      pair = key_bank[k / 2];
      return (k % 2) ? pair[31:0] : pair[63:32];
    endfunction

    // Add subkey, substitute each nibble through row k, rotate left by 11
    function logic [31:0] round_word(logic [31:0] half, int unsigned k);
      logic [31:0] sum;
      logic [31:0] subst;
      sum = half + subkey_word(k);
      for (int i = 0; i < NIB_N; i++) subst[4*i +: 4] = sbox_rows[k][sum[4*i +: 4]];
      return {subst[20:0], subst[31:21]};
    endfunction

    function logic [BLK_W-1:0] cipher_block(logic [BLK_W-1:0] blk, bit dec);
      logic [31:0] n1;
      logic [31:0] n2;
      logic [31:0] held;
      int unsigned fwd;
      int unsigned k;
      n1  = blk[63:32];
      n2  = blk[31:0];
      fwd = dec ? 8 : ROUNDS - 8;
      for (int unsigned r = 0; r < ROUNDS; r++) begin
        k    = (r < fwd) ? (r % NUM_KEYS) : ((ROUNDS - 1 - r) % NUM_KEYS);
        held = n1;
        n1   = round_word(n1, k) ^ n2;
        n2   = held;
      end
      return {n2, n1};
    endfunction

    function void note_transfer(logic [1:0] cmd, logic [IN_DATA_W-1:0] data);
      case (cmd)
        CMD_ENC: begin
          expected_blocks.push_back(cipher_block(data[63:0], 1'b0));
        end
        CMD_DEC: begin
          expected_blocks.push_back(cipher_block(data[63:0], 1'b1));
        end
        CMD_LOAD: begin
          for (int e = 0; e < 16; e++) sbox_rows[data[66:64]][e] = data[67 + 4*e +: 4];
        end
        default: begin
          // dropped: no result, state unchanged
        end
      endcase
    endfunction

    function void check_block(logic [BLK_W-1:0] got);
      logic [BLK_W-1:0] want;
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("unexpected result_block %h", got);
        return;
      end
      want = expected_blocks.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result_block mismatch: expected %h, actual %h", want, got);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs
  // --------------------------------------------------------------------------
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;
  logic [1:0]           in_tuser   = CMD_ENC;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [BLK_W-1:0]     out_tdata;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [4:0]           paddr      = '0;
  logic [63:0]          pwdata     = '0;
  logic [63:0]          prdata;
  logic                 pready;

  int unsigned    in_idle_pct   = 0;
  int unsigned    out_stall_pct = 0;
  cipher_checker  sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gost_feistel_block_cipher u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Observe transfers on both streams; randomise the receiver's stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_transfer(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_block(out_tdata);
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Present one item, idling first at random, and hold until its transfer
  task automatic send_item(input logic [1:0] cmd, input logic [63:0] blk,
                           input logic [2:0] row, input logic [63:0] row_val);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'd0, row_val, row, blk};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random_item();
    int unsigned  pick;
    logic [1:0]   cmd;
    logic [63:0]  blk;
    pick = $urandom_range(99);
    blk  = rand64();
    if ($urandom_range(9) == 0) blk = $urandom_range(1) ? '1 : '0;
    if (pick < 8) cmd = CMD_LOAD;
    else if (pick < 12) cmd = CMD_NONE;
    else cmd = $urandom_range(1) ? CMD_DEC : CMD_ENC;
    send_item(cmd, blk, 3'($urandom_range(7)), rand64());
  endtask

  // Register write: setup phase, then access phase
  task automatic write_key(input int unsigned idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * ADDR_STRIDE);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.key_bank[idx] = val;
    @(posedge clk);
  endtask

  // Drop valid and wait for every expected block, then let the core settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned idle_in [PHASE_N];
    int unsigned stall_out [PHASE_N];
    logic [63:0] key_val;
    idle_in   = '{0, 49, 0, 34};
    stall_out = '{0, 0, 49, 34};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset keys: fill every row before any cipher
    for (int r = 0; r < NUM_KEYS; r++)
      send_item(CMD_LOAD, rand64(), 3'(r),
                (r == 0) ? IDENT_ROW : ((r == NUM_KEYS - 1) ? '1 : rand64()));
    send_item(CMD_ENC, '0, '0, '0);
    send_item(CMD_ENC, '1, '1, '1);
    send_item(CMD_DEC, '0, '1, '1);
    send_item(CMD_DEC, '1, '0, '0);
    send_item(CMD_NONE, '1, '1, '1);
    send_item(CMD_NONE, '0, '0, '0);
    send_item(CMD_LOAD, '1, 3'(NUM_KEYS - 1), rand64());
    send_item(CMD_ENC, rand64(), '0, '0);
    send_item(CMD_DEC, rand64(), '0, '0);
    send_item(CMD_LOAD, '0, 3'd3, '0);
    send_item(CMD_ENC, rand64(), '1, '1);
    send_item(CMD_DEC, rand64(), '1, '1);
    send_item(CMD_ENC, 64'h8000_0000_0000_0001, '0, '0);

    // Random phases, each with its own keys and idling pattern
    for (int p = 0; p < PHASE_N; p++) begin
      wait_idle();
      in_idle_pct   = idle_in[p];
      out_stall_pct = stall_out[p];
      for (int i = 0; i < KREG_N; i++) begin
        case (p)
          0:       key_val = '1;
          2:       key_val = '0;
          default: key_val = rand64();
        endcase
        write_key(i, key_val);
      end
      repeat (PHASE_ITEMS) send_random_item();
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.expected_blocks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop on a hung run
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gfbc_pkg.sv
rtl/gfbc_cfg.sv
rtl/gfbc_dp.sv
rtl/gfbc_ctrl.sv
rtl/gost_feistel_block_cipher.sv
test/tb_gost_feistel_block_cipher.sv
